### rtl/core/drc_pkg.sv
// Shared types and codes for the dirty range coalescer.
// Used by drc_range_unit and dirty_range_coalescer; depends on nothing.
package drc_pkg;

   localparam int RANGE_SLOTS_DEF    = 16;
   localparam int VERTEX_BUFFERS_DEF = 4;

   localparam logic [1:0] OP_MANUAL = 2'd0;
   localparam logic [1:0] OP_SOURCE = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_DRAIN  = 2'd3;

   localparam logic [3:0] STS_MERGED   = 4'd0;
   localparam logic [3:0] STS_APPENDED = 4'd1;
   localparam logic [3:0] STS_AUTO     = 4'd2;
   localparam logic [3:0] STS_ZERO     = 4'd3;
   localparam logic [3:0] STS_BAD_BUF  = 4'd4;
   localparam logic [3:0] STS_RANGE    = 4'd5;
   localparam logic [3:0] STS_OVERFLOW = 4'd6;
   localparam logic [3:0] STS_CLEARED  = 4'd7;
   localparam logic [3:0] STS_DRAINED  = 4'd8;
   localparam logic [3:0] STS_EMPTY    = 4'd9;

   localparam logic [2:0] CSR_AUTO     = 3'd0;
   localparam logic [2:0] CSR_VB_COUNT = 3'd1;
   localparam logic [2:0] CSR_VB0      = 3'd2;
   localparam logic [2:0] CSR_IB       = 3'd6;

   localparam logic [2:0] TGT_INDEX = 3'b100;

   typedef struct packed {
      logic [2:0]  target;
      logic [31:0] offset;
      logic [31:0] size;
   } entry_type;

   typedef struct packed {
      logic        touch;
      logic [32:0] ent_end;
      logic [31:0] mrg_start;
      logic [31:0] mrg_size;
   } span_type;

endpackage

### rtl/core/drc_range_unit.sv
// Overlap test and merge span for one stored range against the new range.
// Depends on drc_pkg.
module drc_range_unit
   import drc_pkg::*;
(
   input  entry_type   ent_i,
   input  logic [2:0]  target_i,
   input  logic [31:0] start_i,
   input  logic [32:0] end_i,
   input  logic [32:0] ent_end_i,
   output span_type    span_o
);

   logic [32:0] ent_end;
   logic [32:0] hi;
   logic [31:0] lo;

   always_comb begin
      ent_end = {1'b0, ent_i.offset} + {1'b0, ent_i.size};
      lo = (ent_i.offset < start_i) ? ent_i.offset : start_i;
      hi = (ent_end_i > end_i) ? ent_end_i : end_i;
      span_o.touch = (ent_i.target == target_i) && !({1'b0, start_i} > ent_end)
                     && !({1'b0, ent_i.offset} > end_i);
      span_o.ent_end = ent_end;
      span_o.mrg_start = lo;
      span_o.mrg_size = 32'(hi - {1'b0, lo});
   end

endmodule

### rtl/core/dirty_range_coalescer.sv
// Dirty range table: merges, appends, clears and drains byte ranges per buffer.
// A mark passes check, a read and compare per slot searched, merge on a touch, finish;
// clear and rejected marks pass check and finish; a drain reads, then outputs, each slot.
// The block holds one item at a time; the slot search through the one-port table
// memory and the shared range unit sets the rate. Synchronous active-high reset
// empties the table and loads register defaults; no clearing pass is needed.
module dirty_range_coalescer
   import drc_pkg::*;
#(
   parameter int RANGE_SLOTS    = RANGE_SLOTS_DEF,
   parameter int VERTEX_BUFFERS = VERTEX_BUFFERS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,  // byte_offset[31:0], byte_size[63:32]
   input  logic [4:0]   req_tuser,  // operation[1:0], target_is_index[2], target_buffer[4:3]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,  // out_offset[31:0], out_size[63:32], bytes_so_far[99:64]
   output logic [6:0]   rsp_tuser,  // status[3:0], out_is_index[4], out_buffer[6:5]
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int SlotW = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
   localparam int CntW  = $clog2(RANGE_SLOTS + 1);
   localparam logic [CntW-1:0] CntFull = CntW'(RANGE_SLOTS);
   localparam logic [2:0] VbMax = 3'(VERTEX_BUFFERS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_SCAN_RD, ST_SCAN_CMP,
      ST_MERGE, ST_FINISH, ST_DRAIN_RD, ST_DRAIN_OUT
   } state_type;

   state_type state_ff, state_in;

   logic        auto_ff, auto_in;
   logic [2:0]  vb_count_ff, vb_count_in;
   logic [31:0] vb_bytes_ff [VERTEX_BUFFERS];
   logic [31:0] vb_bytes_in [VERTEX_BUFFERS];
   logic [31:0] ib_bytes_ff, ib_bytes_in;

   logic [1:0]  op_ff, op_in;
   logic        is_index_ff, is_index_in;
   logic [1:0]  buffer_ff, buffer_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] size_ff, size_in;
   logic [2:0]  target_ff, target_in;
   logic [32:0] new_end_ff, new_end_in;
   logic [32:0] ent_end_ff, ent_end_in;
   logic [31:0] mrg_start_ff, mrg_start_in;
   logic [31:0] mrg_size_ff, mrg_size_in;
   logic [3:0]  pend_ff, pend_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] scan_ff, scan_in;
   logic [35:0] total_ff, total_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_is_index_ff, rsp_is_index_in;
   logic [1:0]  rsp_buffer_ff, rsp_buffer_in;
   logic [31:0] rsp_offset_ff, rsp_offset_in;
   logic [31:0] rsp_size_ff, rsp_size_in;
   logic [35:0] rsp_total_ff, rsp_total_in;
   logic        rsp_last_ff, rsp_last_in;

   entry_type   mem [RANGE_SLOTS];
   entry_type   rd_ff;
   entry_type   mem_wdata;
   logic        mem_we;
   logic [SlotW-1:0] mem_addr;

   logic        out_free;
   logic [31:0] limit;
   logic [32:0] req_end;
   logic        bad_buf;
   span_type    span;

   drc_range_unit u_range (
      .ent_i     (rd_ff),
      .target_i  (target_ff),
      .start_i   (offset_ff),
      .end_i     (new_end_ff),
      .ent_end_i (ent_end_ff),
      .span_o    (span)
   );

   assign mem_addr   = scan_ff[SlotW-1:0];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_total_ff, rsp_size_ff, rsp_offset_ff};
   assign rsp_tuser  = {rsp_buffer_ff, rsp_is_index_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      limit = ib_bytes_ff;
      if (!is_index_ff) begin
         limit = '0;
         for (int i = 0; i < VERTEX_BUFFERS; i++) begin
            if (buffer_ff == 2'(i)) begin
               limit = vb_bytes_ff[i];
            end
         end
      end
      req_end = {1'b0, offset_ff} + {1'b0, size_ff};
      bad_buf = !is_index_ff && (({1'b0, buffer_ff} >= vb_count_ff)
                                 || ({1'b0, buffer_ff} >= VbMax));
   end

   always_comb begin
      state_in = state_ff;
      auto_in = auto_ff;
      vb_count_in = vb_count_ff;
      vb_bytes_in = vb_bytes_ff;
      ib_bytes_in = ib_bytes_ff;
      op_in = op_ff;
      is_index_in = is_index_ff;
      buffer_in = buffer_ff;
      offset_in = offset_ff;
      size_in = size_ff;
      target_in = target_ff;
      new_end_in = new_end_ff;
      ent_end_in = ent_end_ff;
      mrg_start_in = mrg_start_ff;
      mrg_size_in = mrg_size_ff;
      pend_in = pend_ff;
      count_in = count_ff;
      scan_in = scan_ff;
      total_in = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_is_index_in = rsp_is_index_ff;
      rsp_buffer_in = rsp_buffer_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_size_in = rsp_size_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in = rsp_last_ff;
      mem_we = 1'b0;
      mem_wdata = rd_ff;

      if (csr_valid) begin
         if (csr_index == CSR_AUTO) begin
            auto_in = csr_data[0];
         end
         if (csr_index == CSR_VB_COUNT) begin
            vb_count_in = csr_data[2:0];
         end
         if (csr_index == CSR_IB) begin
            ib_bytes_in = csr_data;
         end
         for (int i = 0; i < VERTEX_BUFFERS; i++) begin
            if (csr_index == CSR_VB0 + 3'(i)) begin
               vb_bytes_in[i] = csr_data;
            end
         end
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in = req_tuser[1:0];
               is_index_in = req_tuser[2];
               buffer_in = req_tuser[4:3];
               offset_in = req_tdata[31:0];
               size_in = req_tdata[63:32];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            new_end_in = req_end;
            target_in = is_index_ff ? TGT_INDEX : {1'b0, buffer_ff};
            scan_in = '0;
            total_in = '0;
            state_in = ST_FINISH;
            priority if (op_ff == OP_CLEAR) begin
               pend_in = STS_CLEARED;
            end else if (op_ff == OP_DRAIN) begin
               if (count_ff == '0) begin
                  pend_in = STS_EMPTY;
               end else begin
                  state_in = ST_DRAIN_RD;
               end
            end else if (op_ff == OP_MANUAL && auto_ff) begin
               pend_in = STS_AUTO;
            end else if (size_ff == '0) begin
               pend_in = STS_ZERO;
            end else if (bad_buf) begin
               pend_in = STS_BAD_BUF;
            end else if (req_end > {1'b0, limit}) begin
               pend_in = STS_RANGE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (scan_ff == count_ff) begin
               pend_in = (count_ff == CntFull) ? STS_OVERFLOW : STS_APPENDED;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            ent_end_in = span.ent_end;
            if (span.touch) begin
               state_in = ST_MERGE;
            end else begin
               scan_in = scan_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_MERGE: begin
            mrg_start_in = span.mrg_start;
            mrg_size_in = span.mrg_size;
            pend_in = STS_MERGED;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = pend_ff;
               rsp_is_index_in = 1'b0;
               rsp_buffer_in = '0;
               rsp_offset_in = '0;
               rsp_size_in = '0;
               rsp_total_in = '0;
               rsp_last_in = 1'b1;
               state_in = ST_IDLE;
               unique case (pend_ff)
                  STS_CLEARED, STS_OVERFLOW: begin
                     count_in = '0;
                  end
                  STS_APPENDED: begin
                     mem_we = 1'b1;
                     mem_wdata = '{target: target_ff, offset: offset_ff, size: size_ff};
                     count_in = count_ff + 1'b1;
                  end
                  STS_MERGED: begin
                     mem_we = 1'b1;
                     mem_wdata = '{target: target_ff, offset: mrg_start_ff,
                                   size: mrg_size_ff};
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DRAIN_RD: begin
            state_in = ST_DRAIN_OUT;
         end
         ST_DRAIN_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = STS_DRAINED;
               rsp_is_index_in = rd_ff.target[2];
               rsp_buffer_in = rd_ff.target[2] ? 2'b0 : rd_ff.target[1:0];
               rsp_offset_in = rd_ff.offset;
               rsp_size_in = rd_ff.size;
               rsp_total_in = total_ff + {4'b0, rd_ff.size};
               total_in = total_ff + {4'b0, rd_ff.size};
               rsp_last_in = (CntW'(scan_ff + 1'b1) == count_ff);
               if (CntW'(scan_ff + 1'b1) == count_ff) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  scan_in = scan_ff + 1'b1;
                  state_in = ST_DRAIN_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         auto_ff <= 1'b0;
         vb_count_ff <= 3'd1;
         for (int i = 0; i < VERTEX_BUFFERS; i++) begin
            vb_bytes_ff[i] <= '0;
         end
         ib_bytes_ff <= '0;
         count_ff <= '0;
         scan_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         auto_ff <= auto_in;
         vb_count_ff <= vb_count_in;
         vb_bytes_ff <= vb_bytes_in;
         ib_bytes_ff <= ib_bytes_in;
         count_ff <= count_in;
         scan_ff <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      is_index_ff <= is_index_in;
      buffer_ff <= buffer_in;
      offset_ff <= offset_in;
      size_ff <= size_in;
      target_ff <= target_in;
      new_end_ff <= new_end_in;
      ent_end_ff <= ent_end_in;
      mrg_start_ff <= mrg_start_in;
      mrg_size_ff <= mrg_size_in;
      pend_ff <= pend_in;
      total_ff <= total_in;
      rsp_status_ff <= rsp_status_in;
      rsp_is_index_ff <= rsp_is_index_in;
      rsp_buffer_ff <= rsp_buffer_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_size_ff <= rsp_size_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule
